FILE: rtl/core/rgbfx_pkg.sv
// Shared constants for the RGB LED effect generator.
package rgbfx_pkg;

    localparam int DUTY_MAX_DEF = 1023;
    localparam int DUTY_OUT_W   = 10;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_POWER  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPEED  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BRIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RED    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_GREEN  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLUE   = 3'd6;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_STATIC = 2'd1;
    localparam logic [1:0] MODE_FADE   = 2'd2;
    localparam logic [1:0] MODE_CC     = 2'd3;

    localparam int FADE_MIN   = 5;
    localparam int FADE_STEP  = 10;
    localparam int FADE_BASE  = 50;
    localparam int CC_MIN     = 30;

    // Shared multiplier sizing, covering DUTY_MAX up to 65535.
    localparam int MUL_A_W   = 24;
    localparam int MUL_B_W   = 26;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int DIV_SHIFT = 32;
    localparam int Q_W       = MUL_P_W - DIV_SHIFT;

    // Reciprocals ceil(2^32 / d), exact for dividends below 2^24.
    localparam logic [MUL_B_W-1:0] RECIP_100 = 26'd42949673;
    localparam logic [MUL_B_W-1:0] RECIP_255 = 26'd16843010;

endpackage

FILE: rtl/core/rgb_led_effect_generator.sv
// RGB LED effect generator: top level with sequencer around one shared multiplier.
// Beats are taken in idle only. Off, or fade without a step, goes straight to done;
// static colour forms the brightness in two multiplier passes, then scales each
// colour in two passes and a save; a fade step does only the colour scaling.
// A new beat is taken while the previous result waits in the output register.
// Synchronous active-low reset clears control, fade state and held duties, not r_out.
module rgb_led_effect_generator
    import rgbfx_pkg::*;
#(
    parameter int DUTY_MAX = DUTY_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [31:0]           i_now_ms,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DUTY_OUT_W-1:0] o_red_duty,
    output logic [DUTY_OUT_W-1:0] o_green_duty,
    output logic [DUTY_OUT_W-1:0] o_blue_duty
);

    localparam int DW = $clog2(DUTY_MAX + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_START   = 3'd1;
    localparam logic [2:0] ST_TOP_DIV = 3'd2;
    localparam logic [2:0] ST_TOP_FIX = 3'd3;
    localparam logic [2:0] ST_CH_MUL  = 3'd4;
    localparam logic [2:0] ST_CH_DIV  = 3'd5;
    localparam logic [2:0] ST_CH_SAVE = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    logic [2:0]            r_state, n_state;
    logic                  r_power;
    logic [1:0]            r_mode;
    logic [6:0]            r_speed;
    logic [6:0]            r_bright;
    logic [7:0]            r_red, r_green, r_blue;
    logic [31:0]           r_now;
    logic [DW-1:0]         r_level, n_level;
    logic                  r_falling, n_falling;
    logic [31:0]           r_last, n_last;
    logic [DW-1:0]         r_held [3];
    logic [DW-1:0]         n_held [3];
    logic [DW-1:0]         r_top, n_top;
    logic [1:0]            r_ch, n_ch;
    logic                  r_o_valid, n_o_valid;
    logic [DUTY_OUT_W-1:0] r_out [3];
    logic                  w_load_out;

    logic [MUL_A_W-1:0]    w_a;
    logic [MUL_B_W-1:0]    w_b;
    logic [MUL_P_W-1:0]    w_p;
    logic [Q_W-1:0]        w_q;
    logic [Q_W:0]          w_cc;
    logic [5:0]            w_interval;
    logic [31:0]           w_diff;
    logic                  w_fade_go;
    logic [DW:0]           w_lvl_up;
    logic [7:0]            w_color;

    rgbfx_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    assign w_q        = w_p[MUL_P_W-1:DIV_SHIFT];
    assign w_cc       = {1'b0, w_q} + (Q_W+1)'(CC_MIN);
    assign w_interval = (r_speed[6:1] >= 6'(FADE_BASE)) ? 6'd0 : 6'(FADE_BASE) - r_speed[6:1];
    assign w_diff     = r_now - r_last;
    assign w_fade_go  = w_diff >= {26'd0, w_interval};
    assign w_lvl_up   = {1'b0, r_level} + (DW+1)'(FADE_STEP);

    always_comb begin
        case (r_ch)
            2'd0:    w_color = r_red;
            2'd1:    w_color = r_green;
            default: w_color = r_blue;
        endcase
    end

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            ST_START: begin
                if (r_mode == MODE_STATIC) begin
                    w_a = MUL_A_W'(r_bright);
                    w_b = MUL_B_W'(DUTY_MAX);
                end else begin
                    w_a = MUL_A_W'(r_speed);
                    w_b = MUL_B_W'(DUTY_MAX - CC_MIN);
                end
            end
            ST_TOP_DIV: begin
                w_a = w_p[MUL_A_W-1:0];
                w_b = RECIP_100;
            end
            ST_CH_MUL: begin
                w_a = MUL_A_W'(w_color);
                w_b = MUL_B_W'(r_top);
            end
            ST_CH_DIV: begin
                w_a = w_p[MUL_A_W-1:0];
                w_b = RECIP_255;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_load_out = (r_state == ST_DONE) && (!r_o_valid || i_ready);

    always_comb begin
        n_state   = r_state;
        n_level   = r_level;
        n_falling = r_falling;
        n_last    = r_last;
        n_top     = r_top;
        n_ch      = r_ch;
        n_held    = r_held;
        n_o_valid = r_o_valid;
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (!r_power || r_mode == MODE_OFF) begin
                    n_held[0] = '0;
                    n_held[1] = '0;
                    n_held[2] = '0;
                    n_state   = ST_DONE;
                end else if (r_mode == MODE_FADE) begin
                    if (w_fade_go) begin
                        if (!r_falling) begin
                            if (w_lvl_up >= (DW+1)'(DUTY_MAX)) begin
                                n_level   = DW'(DUTY_MAX);
                                n_falling = 1'b1;
                            end else begin
                                n_level = w_lvl_up[DW-1:0];
                            end
                        end else begin
                            if (r_level <= DW'(FADE_MIN + FADE_STEP)) begin
                                n_level   = DW'(FADE_MIN);
                                n_falling = 1'b0;
                            end else begin
                                n_level = r_level - DW'(FADE_STEP);
                            end
                        end
                        n_top   = n_level;
                        n_last  = r_now;
                        n_ch    = 2'd0;
                        n_state = ST_CH_MUL;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_state = ST_TOP_DIV;
                end
            end
            ST_TOP_DIV: begin
                n_state = ST_TOP_FIX;
            end
            ST_TOP_FIX: begin
                if (r_mode == MODE_STATIC) begin
                    n_top   = (w_q > Q_W'(DUTY_MAX)) ? DW'(DUTY_MAX) : w_q[DW-1:0];
                    n_ch    = 2'd0;
                    n_state = ST_CH_MUL;
                end else begin
                    n_held[0] = (w_cc > (Q_W+1)'(DUTY_MAX)) ? DW'(DUTY_MAX) : w_cc[DW-1:0];
                    n_held[1] = n_held[0];
                    n_held[2] = n_held[0];
                    n_state   = ST_DONE;
                end
            end
            ST_CH_MUL: begin
                n_state = ST_CH_DIV;
            end
            ST_CH_DIV: begin
                n_state = ST_CH_SAVE;
            end
            ST_CH_SAVE: begin
                n_held[r_ch] = w_q[DW-1:0];
                if (r_ch == 2'd2) begin
                    n_state = ST_DONE;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = ST_CH_MUL;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_o_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_power   <= 1'b0;
            r_mode    <= MODE_OFF;
            r_speed   <= '0;
            r_bright  <= '0;
            r_red     <= '0;
            r_green   <= '0;
            r_blue    <= '0;
            r_level   <= '0;
            r_falling <= 1'b0;
            r_last    <= '0;
            r_held[0] <= '0;
            r_held[1] <= '0;
            r_held[2] <= '0;
            r_ch      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_level   <= n_level;
            r_falling <= n_falling;
            r_last    <= n_last;
            r_held    <= n_held;
            r_ch      <= n_ch;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_POWER:  r_power  <= i_cfg_data[0];
                    CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                    CFG_SPEED:  r_speed  <= i_cfg_data[6:0];
                    CFG_BRIGHT: r_bright <= i_cfg_data[6:0];
                    CFG_RED:    r_red    <= i_cfg_data;
                    CFG_GREEN:  r_green  <= i_cfg_data;
                    CFG_BLUE:   r_blue   <= i_cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (r_state == ST_IDLE && i_valid) begin
            r_now <= i_now_ms;
        end
        if (w_load_out) begin
            r_out[0] <= DUTY_OUT_W'(n_held[0]);
            r_out[1] <= DUTY_OUT_W'(n_held[1]);
            r_out[2] <= DUTY_OUT_W'(n_held[2]);
        end
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_o_valid;
    assign o_red_duty   = r_out[0];
    assign o_green_duty = r_out[1];
    assign o_blue_duty  = r_out[2];

endmodule

FILE: rtl/core/rgbfx_mul.sv
// Shared multiplier with registered product.
module rgbfx_mul
    import rgbfx_pkg::*;
(
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_p
);

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

FILE: rtl/core/rgbfx_chk.sv
// Port-level assertion checker for the RGB LED effect generator, with bind.
module rgbfx_chk
    import rgbfx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_ready,
    input  logic                  o_valid,
    input  logic                  i_ready,
    input  logic [DUTY_OUT_W-1:0] o_red_duty,
    input  logic [DUTY_OUT_W-1:0] o_green_duty,
    input  logic [DUTY_OUT_W-1:0] o_blue_duty
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_red_duty) && $stable(o_green_duty)
                                && $stable(o_blue_duty))
        else $error("stalled result beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again before the sequencer finished");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("reset did not clear the result and ready the input");

endmodule

bind rgb_led_effect_generator rgbfx_chk u_rgbfx_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_red_duty   (o_red_duty),
    .o_green_duty (o_green_duty),
    .o_blue_duty  (o_blue_duty)
);

FILE: tb/rgb_led_effect_generator_checker.sv
// Checker for the RGB LED effect generator: predicts held duties per time beat and compares.
`timescale 1ns / 100ps
module rgb_led_effect_generator_checker
    import rgbfx_pkg::*;
#(
    parameter int DUTY_MAX = DUTY_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [DUTY_OUT_W-1:0] i_red_duty,
    input  logic [DUTY_OUT_W-1:0] i_green_duty,
    input  logic [DUTY_OUT_W-1:0] i_blue_duty,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_in_beats,
    output int                    o_out_beats
);

    typedef struct packed {
        logic [DUTY_OUT_W-1:0] red;
        logic [DUTY_OUT_W-1:0] green;
        logic [DUTY_OUT_W-1:0] blue;
    } duty_set_t;

    duty_set_t duty_q[$];

    logic        reg_power;
    logic [1:0]  reg_mode;
    logic [6:0]  reg_speed;
    logic [6:0]  reg_bright;
    logic [7:0]  reg_red;
    logic [7:0]  reg_green;
    logic [7:0]  reg_blue;

    int          ramp_lvl;
    logic        ramp_down;
    logic [31:0] last_tick_ms;
    int unsigned pin_duty [3];

    int fails;
    int in_beats;
    int out_beats;

    function automatic int unsigned scale_color(logic [7:0] c, int unsigned top);
        return int'((longint'(c) * top) / 255);
    endfunction

    task automatic scale_pins(input int unsigned top);
        pin_duty[0] = scale_color(reg_red, top);
        pin_duty[1] = scale_color(reg_green, top);
        pin_duty[2] = scale_color(reg_blue, top);
    endtask

    task automatic fade_tick(input logic [31:0] now);
        int unsigned half;
        int unsigned gap_ms;
        logic [31:0] elapsed;
        half    = reg_speed / 2;
        gap_ms  = (half >= FADE_BASE) ? 0 : FADE_BASE - half;
        elapsed = now - last_tick_ms;
        if (elapsed >= gap_ms) begin
            if (!ramp_down) begin
                ramp_lvl = ramp_lvl + FADE_STEP;
                if (ramp_lvl >= DUTY_MAX) begin
                    ramp_lvl  = DUTY_MAX;
                    ramp_down = 1'b1;
                end
            end else begin
                ramp_lvl = ramp_lvl - FADE_STEP;
                if (ramp_lvl <= FADE_MIN) begin
                    ramp_lvl  = FADE_MIN;
                    ramp_down = 1'b0;
                end
            end
            scale_pins(ramp_lvl);
            last_tick_ms = now;
        end
    endtask

    task automatic update_duties(input logic [31:0] now);
        int unsigned top;
        if (reg_power != 1'b1 || reg_mode == MODE_OFF) begin
            pin_duty = '{0, 0, 0};
        end else begin
            case (reg_mode)
                MODE_STATIC: begin
                    top = (int'(reg_bright) * DUTY_MAX) / 100;
                    if (top > DUTY_MAX) top = DUTY_MAX;
                    scale_pins(top);
                end
                MODE_FADE: begin
                    fade_tick(now);
                end
                default: begin
                    top = (int'(reg_speed) * (DUTY_MAX - CC_MIN)) / 100 + CC_MIN;
                    if (top > DUTY_MAX) top = DUTY_MAX;
                    pin_duty = '{top, top, top};
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        duty_set_t fresh;
        duty_set_t want;
        if (!i_rst_n) begin
            reg_power    = 1'b0;
            reg_mode     = MODE_OFF;
            reg_speed    = '0;
            reg_bright   = '0;
            reg_red      = '0;
            reg_green    = '0;
            reg_blue     = '0;
            ramp_lvl     = 0;
            ramp_down    = 1'b0;
            last_tick_ms = '0;
            pin_duty     = '{0, 0, 0};
            duty_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_POWER:  reg_power  = i_cfg_data[0];
                    CFG_MODE:   reg_mode   = i_cfg_data[1:0];
                    CFG_SPEED:  reg_speed  = i_cfg_data[6:0];
                    CFG_BRIGHT: reg_bright = i_cfg_data[6:0];
                    CFG_RED:    reg_red    = i_cfg_data[7:0];
                    CFG_GREEN:  reg_green  = i_cfg_data[7:0];
                    CFG_BLUE:   reg_blue   = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                update_duties(i_now_ms);
                fresh.red   = DUTY_OUT_W'(pin_duty[0]);
                fresh.green = DUTY_OUT_W'(pin_duty[1]);
                fresh.blue  = DUTY_OUT_W'(pin_duty[2]);
                duty_q.push_back(fresh);
                in_beats++;
            end
            if (i_out_valid && i_out_ready) begin
                out_beats++;
                if (duty_q.size() == 0) begin
                    $error("result beat with no time beat pending: red %0d green %0d blue %0d",
                           i_red_duty, i_green_duty, i_blue_duty);
                    fails++;
                end else begin
                    want = duty_q.pop_front();
                    if (i_red_duty !== want.red) begin
                        $error("red_duty mismatch: expected %0d, actual %0d", want.red,
                               i_red_duty);
                        fails++;
                    end
                    if (i_green_duty !== want.green) begin
                        $error("green_duty mismatch: expected %0d, actual %0d", want.green,
                               i_green_duty);
                        fails++;
                    end
                    if (i_blue_duty !== want.blue) begin
                        $error("blue_duty mismatch: expected %0d, actual %0d", want.blue,
                               i_blue_duty);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= duty_q.size();
        o_in_beats   <= in_beats;
        o_out_beats  <= out_beats;
    end

endmodule

FILE: tb/rgb_led_effect_generator_tb.sv
// Testbench top for the RGB LED effect generator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module rgb_led_effect_generator_tb;
    import rgbfx_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;

    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SEGMENTS       = 5;
    localparam int SEG_ITEMS      = 45;
    localparam int SWEEP_ITEMS    = 230;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    logic                  o_ready;
    logic [31:0]           i_now_ms   = '0;
    logic                  o_valid;
    logic                  i_ready    = 1'b0;
    logic [DUTY_OUT_W-1:0] o_red_duty;
    logic [DUTY_OUT_W-1:0] o_green_duty;
    logic [DUTY_OUT_W-1:0] o_blue_duty;

    int fail_count;
    int pending;
    int in_beats;
    int out_beats;

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    logic        hold_req      = 1'b0;
    logic [31:0] clock_ms      = '0;
    int          quiet_cycles  = 0;

    always #10 i_clk = ~i_clk;

    rgb_led_effect_generator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_now_ms    (i_now_ms),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red_duty  (o_red_duty),
        .o_green_duty(o_green_duty),
        .o_blue_duty (o_blue_duty)
    );

    rgb_led_effect_generator_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_now_ms    (i_now_ms),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_red_duty  (o_red_duty),
        .i_green_duty(o_green_duty),
        .i_blue_duty (o_blue_duty),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_in_beats  (in_beats),
        .o_out_beats (out_beats)
    );

    // Result side: random stalls, and a long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input logic [31:0] now);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_now_ms <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Drop valid, drain every pending result, then let the block settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_percent();
        logic [6:0] v;
        case ($urandom_range(9))
            0:       v = 7'd0;
            1:       v = 7'd100;
            2:       v = 7'd127;
            3:       v = 7'($urandom_range(101, 127));
            default: v = 7'($urandom_range(0, 100));
        endcase
        return {1'($urandom_range(1)), v};
    endfunction

    function automatic logic [7:0] pick_color();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic shuffle_settings();
        int pick;
        logic [1:0] mode;
        wait_idle();
        pick = $urandom_range(99);
        if (pick < 10)      mode = MODE_OFF;
        else if (pick < 35) mode = MODE_STATIC;
        else if (pick < 75) mode = MODE_FADE;
        else                mode = MODE_CC;
        cfg_write(CFG_POWER, {7'($urandom_range(0, 127)), 1'($urandom_range(9) != 0)});
        cfg_write(CFG_MODE, {6'($urandom_range(0, 63)), mode});
        cfg_write(CFG_SPEED, pick_percent());
        cfg_write(CFG_BRIGHT, pick_percent());
        cfg_write(CFG_RED, pick_color());
        cfg_write(CFG_GREEN, pick_color());
        cfg_write(CFG_BLUE, pick_color());
        if ($urandom_range(4) == 0) cfg_write(CFG_UNUSED, 8'($urandom_range(0, 255)));
    endtask

    // Mostly forward time with steps around the fade interval, some jumps and repeats.
    task automatic run_segment(input int n_items);
        if ($urandom_range(3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
        repeat (n_items) begin
            case ($urandom_range(19))
                0:       clock_ms = $urandom();
                1:       ;
                2, 3:    clock_ms = clock_ms + $urandom_range(45, 60);
                default: clock_ms = clock_ms + $urandom_range(0, 30);
            endcase
            send_beat(clock_ms);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: power off at reset, static extremes, colour change, fade timing.
        send_beat(32'd0);
        wait_idle();
        cfg_write(CFG_POWER, 8'h01);
        cfg_write(CFG_MODE, {6'd0, MODE_STATIC});
        cfg_write(CFG_BRIGHT, 8'd100);
        cfg_write(CFG_RED, 8'hFF);
        cfg_write(CFG_GREEN, 8'h00);
        cfg_write(CFG_BLUE, 8'h80);
        send_beat(32'd1);
        wait_idle();
        cfg_write(CFG_BRIGHT, 8'd0);
        send_beat(32'd2);
        wait_idle();
        cfg_write(CFG_BRIGHT, 8'h7F);
        cfg_write(CFG_GREEN, 8'h01);
        cfg_write(CFG_BLUE, 8'hFE);
        send_beat(32'd3);
        wait_idle();
        cfg_write(CFG_BRIGHT, 8'hE4);
        send_beat(32'd4);
        wait_idle();
        cfg_write(CFG_MODE, {6'h3F, MODE_CC});
        cfg_write(CFG_SPEED, 8'd0);
        send_beat(32'd5);
        wait_idle();
        cfg_write(CFG_SPEED, 8'd100);
        send_beat(32'd6);
        wait_idle();
        cfg_write(CFG_SPEED, 8'hFF);
        send_beat(32'd7);
        wait_idle();
        cfg_write(CFG_UNUSED, 8'hFF);
        send_beat(32'd8);
        wait_idle();
        cfg_write(CFG_MODE, {6'd0, MODE_OFF});
        send_beat(32'd9);
        wait_idle();
        cfg_write(CFG_MODE, {6'd0, MODE_STATIC});
        cfg_write(CFG_POWER, 8'hFE);
        send_beat(32'd9);
        wait_idle();
        cfg_write(CFG_POWER, 8'h01);
        cfg_write(CFG_MODE, {6'd0, MODE_FADE});
        cfg_write(CFG_SPEED, 8'd0);
        cfg_write(CFG_RED, 8'hFF);
        cfg_write(CFG_GREEN, 8'hFF);
        cfg_write(CFG_BLUE, 8'hFF);
        send_beat(32'd10);
        send_beat(32'd49);
        send_beat(32'd50);
        send_beat(32'd99);
        send_beat(32'd100);
        wait_idle();
        cfg_write(CFG_SPEED, 8'd101);
        send_beat(32'd100);
        send_beat(32'd100);
        wait_idle();
        cfg_write(CFG_SPEED, 8'd99);
        send_beat(32'd100);
        send_beat(32'd101);
        send_beat(32'hFFFF_FFF0);
        wait_idle();
        cfg_write(CFG_SPEED, 8'd0);
        send_beat(32'h0000_0021);
        send_beat(32'h0000_0022);

        // Random: four idling phases, each a run of segments with fresh settings.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 49; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 49; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                shuffle_settings();
                if (ph == 0 && seg == 1) hold_req = 1'b1;
                run_segment(SEG_ITEMS);
            end
            if (ph == 0) begin
                // Step on every beat long enough to sweep the full triangle both ways.
                wait_idle();
                cfg_write(CFG_POWER, 8'h01);
                cfg_write(CFG_MODE, {6'd0, MODE_FADE});
                cfg_write(CFG_SPEED, 8'd100);
                cfg_write(CFG_RED, pick_color());
                cfg_write(CFG_GREEN, pick_color());
                cfg_write(CFG_BLUE, pick_color());
                run_segment(SWEEP_ITEMS);
            end
        end

        wait_idle();
        $display("Run covered %0d time beats and %0d result beats across off, static,",
                 in_beats, out_beats);
        $display("fade and colour-change settings, power toggles, saturation, time wrap, stalls.");
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("failures: %0d, results still pending: %0d", fail_count, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
